// ===== src/sha256_hasher_top_macros.svh =====
// assertion macros for the sha256 hasher
// used by the controller
`ifndef SHA256_HASHER_TOP_MACROS_SVH
`define SHA256_HASHER_TOP_MACROS_SVH
`define SHA_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("sha256 check failed");
`define SHA_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("sha256 check failed");
`endif

// ===== src/sha_pkg.sv =====
// shared types, constants and round functions for the sha256 hasher
// no dependencies
package sha_pkg;
  typedef struct packed {
    logic [31:0] msg_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        last_digest;
  } sha_out_t;

  // controller to datapath commands
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_PUT   = 3'd1;
  localparam logic [2:0] CMD_START = 3'd2;
  localparam logic [2:0] CMD_ROUND = 3'd3;
  localparam logic [2:0] CMD_FOLD  = 3'd4;
  localparam logic [2:0] CMD_INIT  = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] byte_val;
    logic [5:0] round;
  } sha_cmd_t;

  localparam logic [255:0] INIT_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage

// ===== src/sha_datapath.sv =====
// message block, schedule, working registers and chaining words
// depends on sha_pkg
module sha_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  sha_pkg::sha_cmd_t cmd,
  input  logic [2:0]        sel,
  output logic [31:0]       chain_word
);
  import sha_pkg::*;

  logic [31:0] w_r [16];
  logic [31:0] v_r [8];
  logic [31:0] h_r [8];
  logic [5:0]  fill_r;
  logic [31:0] ws, x2, x15, t1, t2, e, a;
  logic [3:0]  idx;
  logic [1:0]  bpos;

  assign idx  = fill_r[5:2];
  assign bpos = fill_r[1:0];
  assign x2   = w_r[4'(cmd.round - 6'd2)];
  assign x15  = w_r[4'(cmd.round - 6'd15)];
  assign e    = v_r[4];
  assign a    = v_r[0];

  always_comb begin
    if (cmd.round >= 6'd16)
      ws = w_r[cmd.round[3:0]] + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10))
         + w_r[4'(cmd.round - 6'd7)] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3));
    else
      ws = w_r[cmd.round[3:0]];
    t1 = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
       + (v_r[6] ^ (e & (v_r[5] ^ v_r[6]))) + round_k(cmd.round) + ws;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + (((a | v_r[1]) & v_r[2]) | (a & v_r[1]));
  end

  assign chain_word = h_r[sel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      for (int j = 0; j < 8; j++) h_r[j] <= INIT_HASH[255 - 32*j -: 32];
    end else begin
      unique case (cmd.op)
        CMD_PUT: begin
          if (bpos == 2'd0) w_r[idx] <= {cmd.byte_val, 24'd0};
          else w_r[idx][8*(3-bpos) +: 8] <= cmd.byte_val;
          fill_r <= fill_r + 6'd1;
        end
        CMD_START: for (int j = 0; j < 8; j++) v_r[j] <= h_r[j];
        CMD_ROUND: begin
          w_r[cmd.round[3:0]] <= ws;
          for (int j = 1; j < 4; j++) v_r[j] <= v_r[j-1];
          for (int j = 5; j < 8; j++) v_r[j] <= v_r[j-1];
          v_r[4] <= v_r[3] + t1;
          v_r[0] <= t1 + t2;
        end
        CMD_FOLD: for (int j = 0; j < 8; j++) h_r[j] <= h_r[j] + v_r[j];
        CMD_INIT: begin
          fill_r <= '0;
          for (int j = 0; j < 8; j++) h_r[j] <= INIT_HASH[255 - 32*j -: 32];
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== src/sha_ctrl.sv =====
// controller: byte feeding, padding, rounds and digest output
// depends on sha_pkg and the macro header
`include "sha256_hasher_top_macros.svh"
module sha_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [3:0]         digest_words,
  input  logic               in_valid,
  output logic               in_ready,
  input  sha_pkg::sha_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sha_pkg::sha_out_t  out_data,
  input  logic [31:0]        chain_word,
  output sha_pkg::sha_cmd_t  cmd,
  output logic [2:0]         sel
);
  import sha_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BYTES = 3'd1;
  localparam logic [2:0] ST_PAD   = 3'd2;
  localparam logic [2:0] ST_RND   = 3'd3;
  localparam logic [2:0] ST_FOLD  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;
  localparam logic [2:0] ST_LOAD  = 3'd6;

  logic [2:0]  st_r, st_nxt;
  logic [31:0] word_r, word_nxt;
  logic [2:0]  nb_r, nb_nxt, bi_r, bi_nxt;
  logic        last_r, last_nxt, pad_r, pad_nxt;
  logic [63:0] len_r, len_nxt, plen_r, plen_nxt;
  logic [5:0]  fill_r, fill_nxt, rnd_r, rnd_nxt;
  logic [1:0]  pph_r, pph_nxt;   // 0 marker, 1 zeros, 2 length, 3 done
  logic [2:0]  oi_r, oi_nxt, on_r, on_nxt;
  logic [3:0]  dw_sat;
  logic        put;

  assign dw_sat = (digest_words == 4'd0) ? 4'd1 : (digest_words > 4'd8) ? 4'd8 : digest_words;
  assign in_ready  = (st_r == ST_IDLE);
  assign out_valid = (st_r == ST_OUT);
  assign sel       = oi_r;
  assign out_data.digest_word = chain_word;
  assign out_data.last_digest = (oi_r == on_r);

  always_comb begin
    st_nxt = st_r; word_nxt = word_r; nb_nxt = nb_r; bi_nxt = bi_r; last_nxt = last_r;
    len_nxt = len_r; plen_nxt = plen_r; fill_nxt = fill_r; rnd_nxt = rnd_r;
    pph_nxt = pph_r; oi_nxt = oi_r; on_nxt = on_r; pad_nxt = pad_r;
    cmd = '{op: CMD_NONE, byte_val: 8'd0, round: rnd_r};
    put = 1'b0;
    unique case (st_r)
      ST_IDLE: if (in_valid) begin
        word_nxt = in_data.msg_word;
        last_nxt = in_data.last_word;
        nb_nxt = (!in_data.last_word || in_data.valid_bytes > 3'd4) ? 3'd4
                 : in_data.valid_bytes;
        bi_nxt = 3'd0;
        pad_nxt = 1'b0;
        st_nxt = ST_BYTES;
      end
      ST_BYTES: begin
        if (bi_r == nb_r) begin
          len_nxt = len_r + {58'd0, nb_r, 3'd0};
          if (last_r) begin
            plen_nxt = len_r + {58'd0, nb_r, 3'd0};
            pph_nxt = 2'd0;
            pad_nxt = 1'b1;
            st_nxt = ST_PAD;
          end else st_nxt = ST_IDLE;
        end else begin
          put = 1'b1;
          cmd.op = CMD_PUT;
          cmd.byte_val = word_r[31:24];
          word_nxt = {word_r[23:0], 8'd0};
          bi_nxt = bi_r + 3'd1;
        end
      end
      ST_PAD: begin
        if (pph_r == 2'd3) begin
          on_nxt = 3'(dw_sat - 4'd1);
          oi_nxt = 3'd0;
          st_nxt = ST_OUT;
        end else begin
          put = 1'b1;
          cmd.op = CMD_PUT;
          unique case (pph_r)
            2'd0: begin cmd.byte_val = 8'h80; pph_nxt = (fill_r == 6'd55) ? 2'd2 : 2'd1; end
            2'd1: if (fill_r == 6'd55) pph_nxt = 2'd2;
            default: begin
              cmd.byte_val = plen_r[63:56];
              plen_nxt = {plen_r[55:0], 8'd0};
              if (fill_r == 6'd63) pph_nxt = 2'd3;
            end
          endcase
        end
      end
      // block full: load working registers after the last byte lands
      ST_LOAD: begin
        cmd.op = CMD_START;
        st_nxt = ST_RND;
      end
      ST_RND: begin
        cmd.op = CMD_ROUND;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) st_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.op = CMD_FOLD;
        st_nxt = pad_r ? ST_PAD : ST_BYTES;
      end
      ST_OUT: if (out_ready) begin
        oi_nxt = oi_r + 3'd1;
        if (oi_r == on_r) begin
          cmd.op = CMD_INIT;
          len_nxt = '0;
          fill_nxt = '0;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (put) begin
      fill_nxt = fill_r + 6'd1;
      if (fill_r == 6'd63) begin
        rnd_nxt = 6'd0;
        st_nxt = ST_LOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; len_r <= '0; fill_r <= '0; rnd_r <= '0;
    end else begin
      st_r <= st_nxt; len_r <= len_nxt; fill_r <= fill_nxt; rnd_r <= rnd_nxt;
    end
    word_r <= word_nxt; nb_r <= nb_nxt; bi_r <= bi_nxt; last_r <= last_nxt;
    plen_r <= plen_nxt; pph_r <= pph_nxt; oi_r <= oi_nxt; on_r <= on_nxt;
    pad_r <= pad_nxt;
  end

  `SHA_ASSERT_IMP(a_ready_idle, in_ready, !out_valid)
  `SHA_ASSERT_NXT(a_round_wrap, st_r == ST_RND && rnd_r == 6'd63, st_r == ST_FOLD)
  `SHA_ASSERT_IMP(a_out_range, out_valid, oi_r <= on_r)
  `SHA_ASSERT_NXT(a_full_to_load, put && fill_r == 6'd63, st_r == ST_LOAD && rnd_r == 6'd0)
endmodule

// ===== src/sha256_hasher_top.sv =====
// channel    | ports                               | payload
// request in | in_valid, in_ready, in_data         | sha_in_t
// digest out | out_valid, out_ready, out_data      | sha_out_t
// config     | cfg_we, cfg_data                    | digest_words
// a word is accepted in idle, then its bytes are put into the block one at a time until the byte count ends it
// a full block adds a load of the working registers, 64 rounds and a fold into the chaining words
// a last word adds the padding bytes and up to two blocks, then one output per cycle while out_ready is high
// synchronous active-low reset returns to the initial hash, digest_words 8
// one request at a time; output stalls hold the digest word
// depends on sha_pkg, sha_ctrl and sha_datapath
module sha256_hasher_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  sha_pkg::sha_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sha_pkg::sha_out_t out_data
);
  import sha_pkg::*;

  logic [3:0]  dw_r;
  sha_cmd_t    cmd;
  logic [2:0]  sel;
  logic [31:0] chain_word;

  always_ff @(posedge clk) begin
    if (!rst_n) dw_r <= 4'd8;
    else if (cfg_we) dw_r <= cfg_data;
  end

  sha_ctrl u_ctrl (
    .clk, .rst_n, .digest_words(dw_r), .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .chain_word, .cmd, .sel
  );

  sha_datapath u_dp (.clk, .rst_n, .cmd, .sel, .chain_word);
endmodule

// ===== tb/tb_top.sv =====
// self-checking bench for the sha256 hasher: word requests in, digest words out
// carries its own sha-256 model, random handshake gaps and digest length settings
// depends on sha_pkg and sha256_hasher_top
module tb_top;
  import sha_pkg::*;

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_data = 4'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  sha_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sha_out_t out_data;

  sha256_hasher_top DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  sha_in_t request_q[$];
  sha_out_t digest_q[$];
  logic [31:0] hash_st[8];
  logic [31:0] blk_w[16];
  int unsigned blk_fill;
  logic [63:0] msg_bits;
  logic [3:0] digest_len;
  int errors = 0;
  int n_req = 0;
  int n_msg = 0;
  int n_dig = 0;
  bit gaps_on = 1'b1;
  int in_gap = 0;
  int out_gap = 0;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic compress_block();
    logic [31:0] v[8];
    logic [31:0] t1, t2, x2, x15;
    for (int j = 0; j < 8; j++) v[j] = hash_st[j];
    for (int r = 0; r < 64; r++) begin
      if (r >= 16) begin
        x2 = blk_w[(r - 2) & 15];
        x15 = blk_w[(r - 15) & 15];
        blk_w[r & 15] += (ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10)) + blk_w[(r - 7) & 15]
                         + (ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3));
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + RK[r] + blk_w[r & 15];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + (((v[0] | v[1]) & v[2]) | (v[0] & v[1]));
      for (int j = 7; j > 0; j--) v[j] = v[j - 1];
      v[4] += t1;
      v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_st[j] += v[j];
  endtask

  task automatic push_byte(input logic [7:0] b);
    int idx;
    idx = blk_fill >> 2;
    if ((blk_fill & 3) == 0) blk_w[idx] = '0;
    blk_w[idx] |= 32'(b) << ((3 - (blk_fill & 3)) * 8);
    blk_fill++;
    if (blk_fill == 64) begin
      blk_fill = 0;
      compress_block();
    end
  endtask

  task automatic restart_hash();
    for (int j = 0; j < 8; j++) hash_st[j] = IV[j];
    blk_fill = 0;
    msg_bits = '0;
  endtask

  task automatic hash_request(input sha_in_t req);
    int nb, nd;
    logic [63:0] len;
    nb = (!req.last_word || req.valid_bytes > 4) ? 4 : int'(req.valid_bytes);
    for (int i = 0; i < nb; i++) push_byte(req.msg_word[31 - 8 * i -: 8]);
    msg_bits += 64'(nb * 8);
    if (req.last_word) begin
      len = msg_bits;
      push_byte(8'h80);
      while (blk_fill != 56) push_byte(8'h00);
      for (int i = 0; i < 8; i++) push_byte(len[63 - 8 * i -: 8]);
      nd = (digest_len == 0) ? 1 : (digest_len > 8) ? 8 : int'(digest_len);
      for (int i = 0; i < nd; i++) digest_q.push_back('{hash_st[i], i == nd - 1});
      restart_hash();
      n_msg++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      bit busy;
      busy = in_valid;
      if (in_valid && in_ready) begin
        hash_request(request_q.pop_front());
        n_req++;
        busy = 1'b0;
        in_gap = pick_gap();
      end
      if (!busy) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= request_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // digest monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        sha_out_t exp_d;
        if (digest_q.size() == 0) begin
          report($sformatf("unexpected digest word %h", out_data.digest_word));
        end else begin
          exp_d = digest_q.pop_front();
          n_dig++;
          if (out_data.digest_word !== exp_d.digest_word)
            report($sformatf("digest_word %h, expected %h", out_data.digest_word,
                             exp_d.digest_word));
          if (out_data.last_digest !== exp_d.last_digest)
            report($sformatf("last_digest %b, expected %b", out_data.last_digest,
                             exp_d.last_digest));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  task automatic add_req(input logic [31:0] w, input logic [2:0] vb, input bit lst);
    request_q.push_back('{w, vb, lst});
  endtask

  task automatic add_msg(input int words, input logic [2:0] vb);
    for (int i = 0; i < words; i++) add_req($urandom, 3'($urandom_range(0, 7)), 1'b0);
    add_req($urandom, vb, 1'b1);
  endtask

  task automatic drain();
    while (request_q.size() > 0 || digest_q.size() > 0 || in_valid) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_digest_len(input logic [3:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    digest_len = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int words;
    logic [2:0] vb;
    digest_len = 4'd8;
    restart_hash();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty message, then extreme words and saturated byte counts
    add_req($urandom, 3'd0, 1'b1);
    add_req(32'hffffffff, 3'd4, 1'b1);
    add_req(32'h00000000, 3'd7, 1'b1);
    add_req(32'h61626300, 3'd3, 1'b1);
    add_req(32'haaaaaaaa, 3'd1, 1'b0);
    add_req(32'h55555555, 3'd5, 1'b1);
    drain();
    set_digest_len(4'd0);
    add_msg(13, 3'd3);
    add_msg(14, 3'd0);
    drain();
    set_digest_len(4'd15);
    add_msg(0, 3'd2);
    add_msg(15, 3'd4);
    drain();
    set_digest_len(4'd1);
    add_msg(1, 3'd6);
    drain();

    while (n_req < 280) begin
      gaps_on = $urandom_range(0, 3) != 0;
      set_digest_len(4'($urandom_range(0, 15)));
      repeat ($urandom_range(1, 4)) begin
        words = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 34) : $urandom_range(0, 8);
        vb = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        add_msg(words, vb);
      end
      drain();
    end
    gaps_on = 1'b1;
    set_digest_len(4'd8);
    add_msg(3, 3'd4);
    drain();

    $display("covered %0d requests in %0d messages, %0d digest words checked",
             n_req, n_msg, n_dig);
    $display("digest lengths from 0 to 15, saturated byte counts, block-boundary padding");
    if (errors == 0) begin
      $display("sha256_hasher_top test passed");
    end else begin
      $display("sha256_hasher_top test failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("sha256_hasher_top test failed");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+src
src/sha_pkg.sv
src/sha_datapath.sv
src/sha_ctrl.sv
src/sha256_hasher_top.sv
tb/tb_top.sv
